// ===== hw/rtl/lfucp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfucp_pkg
// Shared types and constants for the LFU cache with recency tie break.
// ----------------------------------------------------------------------------
package lfucp_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;

    localparam int PORT_KEY_W   = 32;
    localparam int PORT_VALUE_W = 32;
    localparam int CFG_W        = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_GET_HIT = 2'd1,
        OP_PUT_HIT = 2'd2,
        OP_FILL    = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     sel;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/lfucp_cell.sv =====
// ----------------------------------------------------------------------------
// lfucp_cell
// One cache entry: key match, count and recency update, and one stage of the
// victim search chain that hands the best candidate so far to the next cell.
// ----------------------------------------------------------------------------
module lfucp_cell
    import lfucp_pkg::*;
#(
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int RANK_W     = 4,
    parameter int IDX_W      = 4,
    parameter int CELL_INDEX = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic [RANK_W-1:0]     ref_rank,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [VALUE_BITS-1:0] wr_value,
    output logic                  valid,
    output logic                  hit,
    output logic [VALUE_BITS-1:0] rd_value,
    output logic [RANK_W-1:0]     rank,
    input  logic                  cnd_have_in,
    input  logic [COUNT_BITS-1:0] cnd_count_in,
    input  logic [RANK_W-1:0]     cnd_rank_in,
    input  logic [IDX_W-1:0]      cnd_idx_in,
    output logic                  cnd_have_out,
    output logic [COUNT_BITS-1:0] cnd_count_out,
    output logic [RANK_W-1:0]     cnd_rank_out,
    output logic [IDX_W-1:0]      cnd_idx_out
);

    logic                  valid_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [RANK_W-1:0]     rank_reg;
    logic                  take_self;
    logic                  older;

    assign valid    = valid_reg;
    assign hit      = valid_reg && (key_reg == wr_key);
    assign rd_value = value_reg;
    assign rank     = rank_reg;
    assign older    = valid_reg && (rank_reg < ref_rank);

    // lowest count wins; among equal counts the older entry
    assign take_self = valid_reg && (!cnd_have_in || (count_reg < cnd_count_in) ||
                       ((count_reg == cnd_count_in) && (rank_reg > cnd_rank_in)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.op == OP_FILL && ctrl.sel)
        begin
            valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op) inside
            OP_GET_HIT, OP_PUT_HIT:
            begin
                if (ctrl.sel)
                begin
                    if (count_reg != '1)
                        count_reg <= count_reg + 1'b1;
                    rank_reg <= '0;
                    if (ctrl.op == OP_PUT_HIT)
                        value_reg <= wr_value;
                end
                else if (older)
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
            OP_FILL:
            begin
                if (ctrl.sel)
                begin
                    key_reg   <= wr_key;
                    value_reg <= wr_value;
                    count_reg <= COUNT_BITS'(1);
                    rank_reg  <= '0;
                end
                else if (older)
                begin
                    rank_reg <= rank_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take_self)
        begin
            cnd_have_out  <= 1'b1;
            cnd_count_out <= count_reg;
            cnd_rank_out  <= rank_reg;
            cnd_idx_out   <= IDX_W'(CELL_INDEX);
        end
        else
        begin
            cnd_have_out  <= cnd_have_in;
            cnd_count_out <= cnd_count_in;
            cnd_rank_out  <= cnd_rank_in;
            cnd_idx_out   <= cnd_idx_in;
        end
    end

endmodule

// ===== hw/rtl/lfu_cache_policy_core.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_policy_core
// Fully associative key/value store with LFU replacement, LRU among ties.
//
//   channel | direction | handshake             | beat
//   req     | in        | req_valid / req_stall | command, key, value
//   rsp     | out       | rsp_valid / rsp_stall | hit, read_value
//   cfg     | in        | cfg_valid / cfg_ready | cfg_data (capacity)
//
// A request passes the look-up state and then the finish state; a put that
// misses in a full store runs a victim search in between, which walks the
// cell chain, one cell a cycle. One request is in work at a time; a finished
// beat waits in the output register while the next request is taken. Reset
// clears all valid bits at once, so no clearing pass follows it.
// ----------------------------------------------------------------------------
module lfu_cache_policy_core
    import lfucp_pkg::*;
#(
    parameter int ENTRIES    = ENTRIES_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    output logic                    req_stall,
    input  logic                    command,
    input  logic [PORT_KEY_W-1:0]   key,
    input  logic [PORT_VALUE_W-1:0] value,
    output logic                    rsp_valid,
    input  logic                    rsp_stall,
    output logic                    hit,
    output logic [PORT_VALUE_W-1:0] read_value,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_W-1:0]        cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOK   = 4'b0010,
        ST_SWEEP  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        capacity_reg;
    logic [OCC_W-1:0]        occ_reg;
    logic [OCC_W-1:0]        sweep_reg;
    logic                    cmd_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [VALUE_BITS-1:0]   value_reg;
    cell_op_t                op_reg;
    logic [IDX_W-1:0]        tgt_reg;
    logic [RANK_W-1:0]       ref_reg;
    logic                    hit_res_reg;
    logic [PORT_VALUE_W-1:0] rdata_reg;
    logic                    rsp_valid_reg;
    logic                    hit_out_reg;
    logic [PORT_VALUE_W-1:0] read_value_reg;

    logic                    cell_valid [ENTRIES];
    logic                    cell_hit   [ENTRIES];
    logic [VALUE_BITS-1:0]   cell_value [ENTRIES];
    logic [RANK_W-1:0]       cell_rank  [ENTRIES];
    cell_ctrl_t              cell_ctrl  [ENTRIES];

    logic                    ch_have  [ENTRIES+1];
    logic [COUNT_BITS-1:0]   ch_count [ENTRIES+1];
    logic [RANK_W-1:0]       ch_rank  [ENTRIES+1];
    logic [IDX_W-1:0]        ch_idx   [ENTRIES+1];

    logic                    any_hit;
    logic [IDX_W-1:0]        hit_idx;
    logic [IDX_W-1:0]        free_idx;
    logic [CMP_W-1:0]        cap_eff;
    logic                    full;
    logic                    out_free;
    logic                    apply;

    assign cfg_ready  = 1'b1;
    assign req_stall  = (state_reg != ST_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign hit        = hit_out_reg;
    assign read_value = read_value_reg;

    assign cap_eff  = (CMP_W'(capacity_reg) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                               : CMP_W'(capacity_reg);
    assign full     = (CMP_W'(occ_reg) >= cap_eff);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign apply    = (state_reg == ST_FINISH) && out_free;

    // lowest matching slot and lowest free slot
    always_comb
    begin
        any_hit  = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (cell_hit[i])
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!cell_valid[i])
                free_idx = IDX_W'(i);
        end
    end

    assign ch_have[0]  = 1'b0;
    assign ch_count[0] = '0;
    assign ch_rank[0]  = '0;
    assign ch_idx[0]   = '0;

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        always_comb
        begin
            cell_ctrl[g].op  = apply ? op_reg : OP_NONE;
            cell_ctrl[g].sel = (tgt_reg == IDX_W'(g));
        end

        lfucp_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .RANK_W     (RANK_W),
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .ctrl          (cell_ctrl[g]),
            .ref_rank      (ref_reg),
            .wr_key        (key_reg),
            .wr_value      (value_reg),
            .valid         (cell_valid[g]),
            .hit           (cell_hit[g]),
            .rd_value      (cell_value[g]),
            .rank          (cell_rank[g]),
            .cnd_have_in   (ch_have[g]),
            .cnd_count_in  (ch_count[g]),
            .cnd_rank_in   (ch_rank[g]),
            .cnd_idx_in    (ch_idx[g]),
            .cnd_have_out  (ch_have[g+1]),
            .cnd_count_out (ch_count[g+1]),
            .cnd_rank_out  (ch_rank[g+1]),
            .cnd_idx_out   (ch_idx[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            occ_reg       <= '0;
            sweep_reg     <= '0;
            op_reg        <= OP_NONE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                capacity_reg <= cfg_data;

            // drop the old beat unless a new one replaces it on this edge
            if (rsp_valid_reg && !rsp_stall && !apply)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                        state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    if (cmd_reg == CMD_GET)
                    begin
                        state_reg <= ST_FINISH;
                        op_reg    <= any_hit ? OP_GET_HIT : OP_NONE;
                    end
                    else if (capacity_reg == '0)
                    begin
                        state_reg <= ST_FINISH;
                        op_reg    <= OP_NONE;
                    end
                    else if (any_hit)
                    begin
                        state_reg <= ST_FINISH;
                        op_reg    <= OP_PUT_HIT;
                    end
                    else
                    begin
                        op_reg <= OP_FILL;
                        if (full)
                        begin
                            state_reg <= ST_SWEEP;
                            sweep_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                            occ_reg   <= occ_reg + 1'b1;
                        end
                    end
                end
                ST_SWEEP:
                begin
                    // candidate passes through one chain register per cell to reach the chain end
                    if (sweep_reg == OCC_W'(ENTRIES))
                        state_reg <= ST_FINISH;
                    else
                        sweep_reg <= sweep_reg + 1'b1;
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg     <= ST_IDLE;
                        rsp_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            cmd_reg   <= command;
            key_reg   <= KEY_BITS'(key);
            value_reg <= VALUE_BITS'(value);
        end

        if (state_reg == ST_LOOK)
        begin
            hit_res_reg <= any_hit;
            rdata_reg   <= (cmd_reg == CMD_GET && any_hit)
                           ? PORT_VALUE_W'(cell_value[hit_idx]) : '0;
            if (any_hit)
            begin
                tgt_reg <= hit_idx;
                ref_reg <= cell_rank[hit_idx];
            end
            else
            begin
                // free slot: every valid entry ages by one
                tgt_reg <= free_idx;
                ref_reg <= '1;
            end
        end

        if (state_reg == ST_SWEEP && sweep_reg == OCC_W'(ENTRIES))
        begin
            tgt_reg <= ch_idx[ENTRIES];
            ref_reg <= ch_rank[ENTRIES];
        end

        if (apply)
        begin
            hit_out_reg    <= hit_res_reg;
            read_value_reg <= rdata_reg;
        end
    end

endmodule
